[src/acme_pkg.sv]
`default_nettype none

package acme_pkg;

  localparam int DATA_WORDS_DEF = 10;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int OPC_W     = 4;
  localparam int ADDR_W    = 4;
  localparam int IVAL_W    = 16;
  localparam int PC_W      = 8;
  localparam int ACC_OUT_W = 16;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD   = 4'd1,
    OP_ADD    = 4'd2,
    OP_STORE  = 4'd3,
    OP_SUB    = 4'd4,
    OP_INPUT  = 4'd5,
    OP_OUTPUT = 4'd6,
    OP_END    = 4'd7,
    OP_JUMP   = 4'd8,
    OP_SKIP   = 4'd9
  } opcode_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_wr_t;

endpackage

`default_nettype wire

[src/accumulator_machine_execute_top.sv]
// channel | handshake          | fields
// in      | in_valid/in_ready   | in_opcode, in_operand_address, in_input_value
// out     | out_valid/out_ready | out_next_pc, out_acc_value, out_output_strobe, out_halted
//
// One instruction per cycle while the output is not stalled: an item waits in the input register,
// executes against acc/pc/data memory and lands in the output register.
// Synchronous active-low reset clears acc, pc, halt flag and data memory.
// A stalled output holds its item; the input register still takes one more.
`default_nettype none

module accumulator_machine_execute_top import acme_pkg::*; #(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic        [OPC_W-1:0]     in_opcode,
  input  wire logic        [ADDR_W-1:0]    in_operand_address,
  input  wire logic signed [IVAL_W-1:0]    in_input_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [PC_W-1:0]      out_next_pc,
  output logic signed      [ACC_OUT_W-1:0] out_acc_value,
  output logic                             out_output_strobe,
  output logic                             out_halted
);

  localparam int XW = (DATA_WIDTH > ACC_OUT_W) ? DATA_WIDTH : ACC_OUT_W;

  logic                     in_v_r;
  logic [OPC_W-1:0]         opc_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [IVAL_W-1:0] ival_r;

  logic [DATA_WIDTH-1:0] acc_r;
  logic [DATA_WIDTH-1:0] acc_nxt;
  logic [PC_W-1:0]       pc_r;
  logic [PC_W-1:0]       pc_nxt;
  logic                  halt_r;
  logic                  halt_nxt;
  logic                  strobe;
  mem_wr_t               mem_wr;
  mem_wr_t               mem_wr_q;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [XW-1:0]         acc_x;

  logic                 out_v_r;
  logic [PC_W-1:0]      out_pc_r;
  logic [ACC_OUT_W-1:0] out_acc_r;
  logic                 out_strobe_r;
  logic                 out_halt_r;

  logic exec_go;

  assign exec_go  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || exec_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opc_r  <= in_opcode;
      addr_r <= in_operand_address;
      ival_r <= in_input_value;
    end
  end

  acme_regfile #(
    .DATA_WORDS (DATA_WORDS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mem_wr_q),
    .wdata (acc_r),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  acme_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .opcode    (opc_r),
    .addr      (addr_r),
    .ival      (ival_r),
    .acc       (acc_r),
    .pc        (pc_r),
    .halt      (halt_r),
    .mem_rdata (mem_rdata),
    .acc_nxt   (acc_nxt),
    .pc_nxt    (pc_nxt),
    .halt_nxt  (halt_nxt),
    .strobe    (strobe),
    .mem_wr    (mem_wr)
  );

  always_comb begin
    mem_wr_q      = mem_wr;
    mem_wr_q.en   = mem_wr.en && exec_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else if (exec_go) begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  assign acc_x = XW'(acc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (exec_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_pc_r     <= pc_nxt;
      out_acc_r    <= acc_x[ACC_OUT_W-1:0];
      out_strobe_r <= strobe;
      out_halt_r   <= halt_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_next_pc       = out_pc_r;
  assign out_acc_value     = out_acc_r;
  assign out_output_strobe = out_strobe_r;
  assign out_halted        = out_halt_r;

endmodule

`default_nettype wire

[src/acme_regfile.sv]
`default_nettype none

module acme_regfile import acme_pkg::*; #(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mem_wr_t               wr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic [DATA_WIDTH-1:0] mem_r [DATA_WORDS];
  logic                  rd_in_range;
  logic                  wr_in_range;

  assign rd_in_range = ({1'b0, raddr} < (ADDR_W + 1)'(DATA_WORDS));
  assign wr_in_range = ({1'b0, wr.addr} < (ADDR_W + 1)'(DATA_WORDS));

  assign rdata = rd_in_range ? mem_r[raddr[IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DATA_WORDS; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en && wr_in_range) begin
      mem_r[wr.addr[IDX_W-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

[src/acme_alu.sv]
`default_nettype none

module acme_alu import acme_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        [OPC_W-1:0]      opcode,
  input  wire logic        [ADDR_W-1:0]     addr,
  input  wire logic signed [IVAL_W-1:0]     ival,
  input  wire logic        [DATA_WIDTH-1:0] acc,
  input  wire logic        [PC_W-1:0]       pc,
  input  wire logic                         halt,
  input  wire logic        [DATA_WIDTH-1:0] mem_rdata,
  output logic             [DATA_WIDTH-1:0] acc_nxt,
  output logic             [PC_W-1:0]       pc_nxt,
  output logic                              halt_nxt,
  output logic                              strobe,
  output mem_wr_t                           mem_wr
);

  localparam int XW = (DATA_WIDTH > IVAL_W) ? DATA_WIDTH : IVAL_W;

  logic signed [XW-1:0]   ival_x;
  logic        [PC_W-1:0] pc_inc;

  assign ival_x = XW'(ival);
  assign pc_inc = pc + PC_W'(1);

  always_comb begin
    acc_nxt     = acc;
    pc_nxt      = pc;
    halt_nxt    = halt;
    strobe      = 1'b0;
    mem_wr.en   = 1'b0;
    mem_wr.addr = addr;
    if (!halt) begin
      pc_nxt = pc_inc;
      unique case (opcode_t'(opcode))
        OP_LOAD:   acc_nxt = mem_rdata;
        OP_ADD:    acc_nxt = acc + mem_rdata;
        OP_STORE:  mem_wr.en = 1'b1;
        OP_SUB:    acc_nxt = acc - mem_rdata;
        OP_INPUT:  acc_nxt = ival_x[DATA_WIDTH-1:0];
        OP_OUTPUT: strobe = 1'b1;
        OP_END:    halt_nxt = 1'b1;
        OP_JUMP:   pc_nxt = PC_W'(addr);
        OP_SKIP: begin
          if (acc == '0) begin
            pc_nxt = pc_inc + PC_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/accumulator_machine_execute_top_tb.sv]
`timescale 1ns / 100ps

module accumulator_machine_execute_top_tb;
  import acme_pkg::*;

  localparam int RAND_ITEMS = 2000;
  localparam int QUIET_ITEMS = 300;
  localparam int CHUNK = 300;
  localparam int DIR_ROWS = 23;
  localparam int TAIL_ROWS = 6;
  localparam logic [OPC_W-1:0] OP_NONE_LO = 4'd0;
  localparam logic [OPC_W-1:0] OP_NONE_HI = 4'd15;

  typedef struct packed {
    logic [PC_W-1:0]      pc;
    logic [ACC_OUT_W-1:0] acc;
    logic                 strobe;
    logic                 halted;
  } result_t;

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
    logic [IVAL_W-1:0] val;
    logic              typed;
    result_t           res;
  } instr_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPC_W-1:0] in_opcode = '0;
  logic [ADDR_W-1:0] in_operand_address = '0;
  logic signed [IVAL_W-1:0] in_input_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PC_W-1:0] out_next_pc;
  logic signed [ACC_OUT_W-1:0] out_acc_value;
  logic out_output_strobe;
  logic out_halted;

  // machine state as seen by the checker
  logic [ACC_OUT_W-1:0] mach_acc = '0;
  logic [PC_W-1:0] mach_pc = '0;
  logic [ACC_OUT_W-1:0] mach_mem [DATA_WORDS_DEF];
  logic mach_halted = 1'b0;

  result_t pending_q [$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int idle_pct = 0;
  bit quiet = 1'b0;

  // typed rows carry their expected result in the table; the others take it from the checker model
  instr_t dir_tab [DIR_ROWS] = '{
    '{OP_OUTPUT, 4'd0,  16'h0000, 1'b1, '{8'd1,  16'h0000, 1'b1, 1'b0}},
    '{OP_SKIP,   4'd0,  16'h0000, 1'b1, '{8'd3,  16'h0000, 1'b0, 1'b0}},
    '{OP_INPUT,  4'd0,  16'h7fff, 1'b1, '{8'd4,  16'h7fff, 1'b0, 1'b0}},
    '{OP_STORE,  4'd0,  16'h0000, 1'b0, '0},
    '{OP_ADD,    4'd0,  16'h0000, 1'b0, '0},
    '{OP_SKIP,   4'd0,  16'h0000, 1'b0, '0},
    '{OP_INPUT,  4'd9,  16'h8000, 1'b1, '{8'd8,  16'h8000, 1'b0, 1'b0}},
    '{OP_STORE,  4'd9,  16'h0000, 1'b0, '0},
    '{OP_SUB,    4'd9,  16'h0000, 1'b0, '0},
    '{OP_SUB,    4'd0,  16'h0000, 1'b0, '0},
    '{OP_STORE,  4'd10, 16'h0000, 1'b0, '0},
    '{OP_LOAD,   4'd10, 16'h0000, 1'b0, '0},
    '{OP_LOAD,   4'd9,  16'h0000, 1'b0, '0},
    '{OP_ADD,    4'd15, 16'h0000, 1'b0, '0},
    '{OP_INPUT,  4'd15, 16'hffff, 1'b1, '{8'd16, 16'hffff, 1'b0, 1'b0}},
    '{OP_ADD,    4'd9,  16'h0000, 1'b0, '0},
    '{OP_NONE_LO, 4'd0, 16'h0000, 1'b0, '0},
    '{OP_NONE_HI, 4'd15, 16'hffff, 1'b0, '0},
    '{OP_JUMP,   4'd15, 16'h0000, 1'b0, '0},
    '{OP_INPUT,  4'd0,  16'h0000, 1'b0, '0},
    '{OP_JUMP,   4'd0,  16'h0000, 1'b0, '0},
    '{OP_LOAD,   4'd0,  16'h0000, 1'b0, '0},
    '{OP_OUTPUT, 4'd0,  16'h0000, 1'b0, '0}
  };

  // end of program, then items against a halted machine
  instr_t tail_tab [TAIL_ROWS] = '{
    '{OP_END,     4'd0,  16'h0000, 1'b0, '0},
    '{OP_OUTPUT,  4'd0,  16'h0000, 1'b0, '0},
    '{OP_INPUT,   4'd5,  16'h1234, 1'b0, '0},
    '{OP_JUMP,    4'd3,  16'h0000, 1'b0, '0},
    '{OP_END,     4'd0,  16'h0000, 1'b0, '0},
    '{OP_NONE_HI, 4'd15, 16'hffff, 1'b0, '0}
  };

  accumulator_machine_execute_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_operand_address (in_operand_address),
    .in_input_value     (in_input_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_pc        (out_next_pc),
    .out_acc_value      (out_acc_value),
    .out_output_strobe  (out_output_strobe),
    .out_halted         (out_halted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic execute_instr(input instr_t ins, output result_t res);
    logic [ACC_OUT_W-1:0] rd;
    logic strobe;
    bit in_mem;
    in_mem = int'(ins.addr) < DATA_WORDS_DEF;
    rd = in_mem ? mach_mem[ins.addr] : '0;
    strobe = 1'b0;
    if (!mach_halted) begin
      mach_pc = mach_pc + 8'd1;
      case (ins.op)
        OP_LOAD:   mach_acc = rd;
        OP_ADD:    mach_acc = mach_acc + rd;
        OP_STORE:  if (in_mem) mach_mem[ins.addr] = mach_acc;
        OP_SUB:    mach_acc = mach_acc - rd;
        OP_INPUT:  mach_acc = ins.val;
        OP_OUTPUT: strobe = 1'b1;
        OP_END:    mach_halted = 1'b1;
        OP_JUMP:   mach_pc = {{(PC_W-ADDR_W){1'b0}}, ins.addr};
        OP_SKIP:   if (mach_acc == '0) mach_pc = mach_pc + 8'd1;
        default:   ;
      endcase
    end
    res = '{mach_pc, mach_acc, strobe, mach_halted};
  endtask

  task automatic send_item(input instr_t ins);
    result_t res;
    in_valid <= 1'b1;
    in_opcode <= ins.op;
    in_operand_address <= ins.addr;
    in_input_value <= ins.val;
    do @(posedge clk); while (!in_ready);
    execute_instr(ins, res);
    pending_q.push_back(ins.typed ? ins.res : res);
    sent_cnt++;
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic instr_t random_instr(bit jumps_on);
    instr_t ins;
    int r;
    ins = '0;
    r = $urandom_range(99);
    if (r < 6) begin
      // 16 wraps to opcode 0
      ins.op = OPC_W'($urandom_range(10, 16));
    end else if (r < 10 && jumps_on) begin
      ins.op = OP_JUMP;
    end else begin
      case ($urandom_range(6))
        0: ins.op = OP_LOAD;
        1: ins.op = OP_ADD;
        2: ins.op = OP_STORE;
        3: ins.op = OP_SUB;
        4: ins.op = OP_INPUT;
        5: ins.op = OP_OUTPUT;
        default: ins.op = OP_SKIP;
      endcase
    end
    ins.addr = ADDR_W'(($urandom_range(4) == 0) ? $urandom_range(10, 15) : $urandom_range(9));
    case ($urandom_range(7))
      0: ins.val = 16'h0000;
      1: ins.val = 16'h7fff;
      2: ins.val = 16'h8000;
      3: ins.val = 16'hffff;
      default: ins.val = IVAL_W'($urandom());
    endcase
    return ins;
  endfunction

  // sender
  initial begin
    bit jumps_on;
    for (int k = 0; k < DATA_WORDS_DEF; k++) mach_mem[k] = '0;
    jumps_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k]);
      idle_gap();
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % CHUNK == 0) begin
        jumps_on = (i / CHUNK) % 2 == 0;
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(random_instr(jumps_on));
      if (i == RAND_ITEMS / 2 - 1) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
      end else begin
        idle_gap();
      end
    end

    foreach (tail_tab[k]) send_item(tail_tab[k]);
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver and result check
  initial begin
    int stall_left;
    int hold_left;
    int stall_pct;
    int cyc;
    bit held;
    result_t got;
    result_t want;
    stall_left = 0;
    hold_left = 0;
    stall_pct = 0;
    cyc = 0;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_next_pc, out_acc_value, out_output_strobe, out_halted};
        if (pending_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected item pc %h acc %h strobe %b halted %b",
                     $realtime, got.pc, got.acc, got.strobe, got.halted);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch pc %h/%h acc %h/%h strobe %b/%b halted %b/%b (exp/got)",
                       $realtime, want.pc, got.pc, want.acc, got.acc,
                       want.strobe, got.strobe, want.halted, got.halted);
          end
        end
      end
      cyc++;
      if (cyc % 128 == 0) begin
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      // long hold-off so the pipeline backs up into the input
      if (!held && sent_cnt >= 600) begin
        held = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
